// ===== rtl/vpd_pkg.sv =====
// ============================================================================
// vpd_pkg - shared types and constants for the vertex position dequantiser
// Format codes, the classified item passed from front to back, and widths.
// ============================================================================
package vpd_pkg;

	localparam logic [2:0] FMT_UBYTE = 3'd0;
	localparam logic [2:0] FMT_SBYTE = 3'd1;
	localparam logic [2:0] FMT_UHALF = 3'd2;
	localparam logic [2:0] FMT_SHALF = 3'd3;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_THREE  = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;

	localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

	localparam int QDEPTH = 2;

	// One component after classification: pass-through word or signed magnitude.
	typedef struct packed {
		logic        pass;
		logic        neg;
		logic [31:0] word;   // raw word when pass, else magnitude (<= 2^16)
	} comp_t;

	typedef struct packed {
		comp_t       x;
		comp_t       y;
		comp_t       z;
		logic        force_one;
	} item_t;

endpackage

// ===== rtl/vertex_position_dequantizer_core.sv =====
// ============================================================================
// vertex_position_dequantizer_core - vertex position dequantiser top level
// Converts three raw component words to scaled binary32 values.
// ============================================================================
// Path: a transfer passes the front register, the queue, then the multiply and round stages.
// Throughput: one position per cycle while out_ready stays high; one scale multiply
// per component per cycle in the back stage sets this figure.
// Reset: arst_n clears all valid flags and queue pointers and returns the
// registers to unsigned byte format, three elements and a scale of 1.0.
module vertex_position_dequantizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] raw_x,
	input  logic [31:0] raw_y,
	input  logic [31:0] raw_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] x_bits,
	output logic [31:0] y_bits,
	output logic [31:0] z_bits
);

	logic [2:0]     fmt_q;
	logic           three_q;
	logic [31:0]    scale_q;

	// The user must write the configuration only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= vpd_pkg::FMT_UBYTE;
			three_q <= 1'b1;
			scale_q <= vpd_pkg::ONE_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				vpd_pkg::REG_FORMAT: fmt_q   <= cfg_data[2:0];
				vpd_pkg::REG_THREE:  three_q <= cfg_data[0];
				vpd_pkg::REG_SCALE:  scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic           f_valid, f_ready, b_valid, b_ready;
	vpd_pkg::item_t f_item, b_item;

	// The front classifies each word into a pass-through word or a signed
	// magnitude, so the back needs no knowledge of the format.
	vpd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.valid(in_valid), .ready(in_ready),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
		.fmt(fmt_q), .three(three_q),
		.item_valid_s1(f_valid), .item_ready(f_ready), .item_s1(f_item)
	);

	// The short queue lets the front keep taking transfers while the back waits.
	vpd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	// The back multiplies by the scale and then rounds, one stage each.
	vpd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.scale(scale_q),
		.valid(out_valid), .ready(out_ready),
		.x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits)
	);

endmodule

// ===== rtl/vpd_front.sv =====
// ============================================================================
// vpd_front - input stage
// Accepts a raw position, classifies each word by format and registers it.
// ============================================================================
module vpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	input  logic [31:0]          raw_x,
	input  logic [31:0]          raw_y,
	input  logic [31:0]          raw_z,
	input  logic [2:0]           fmt,
	input  logic                 three,
	output logic                 item_valid_s1,
	input  logic                 item_ready,
	output vpd_pkg::item_t       item_s1
);

	function automatic vpd_pkg::comp_t classify(input logic [31:0] w, input logic [2:0] f);
		vpd_pkg::comp_t c;
		c.pass = 1'b0;
		c.neg  = 1'b0;
		c.word = 32'd0;
		case (f)
			vpd_pkg::FMT_UBYTE: c.word = {24'd0, w[7:0]};
			vpd_pkg::FMT_SBYTE: begin
				c.neg  = w[7];
				c.word = w[7] ? {23'd0, 9'h100 - {1'b0, w[7:0]}} : {24'd0, w[7:0]};
			end
			vpd_pkg::FMT_UHALF: c.word = {16'd0, w[15:0]};
			vpd_pkg::FMT_SHALF: begin
				c.neg  = w[15];
				c.word = w[15] ? {15'd0, 17'h10000 - {1'b0, w[15:0]}} : {16'd0, w[15:0]};
			end
			default: begin
				c.pass = 1'b1;
				c.word = w;
			end
		endcase
		return c;
	endfunction

	assign ready = !item_valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (ready) begin
			item_valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			item_s1.x         <= classify(raw_x, fmt);
			item_s1.y         <= classify(raw_y, fmt);
			item_s1.z         <= classify(raw_z, fmt);
			item_s1.force_one <= !three;
		end
	end

endmodule

// ===== rtl/vpd_queue.sv =====
// ============================================================================
// vpd_queue - short item queue
// Two-entry FIFO that lets the front and back stall independently.
// ============================================================================
module vpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  vpd_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output vpd_pkg::item_t rd_item
);

	vpd_pkg::item_t                       mem_q [vpd_pkg::QDEPTH];
	logic [$clog2(vpd_pkg::QDEPTH)-1:0]   wp_q, rp_q;
	logic [$clog2(vpd_pkg::QDEPTH):0]     cnt_q;
	logic                                 wr, rd;

	assign wr_ready = cnt_q != ($clog2(vpd_pkg::QDEPTH)+1)'(vpd_pkg::QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(vpd_pkg::QDEPTH){1'b0}}, wr} - {{$clog2(vpd_pkg::QDEPTH){1'b0}}, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

endmodule

// ===== rtl/vpd_back.sv =====
// ============================================================================
// vpd_back - scaling pipeline
// Multiplies each magnitude by the scale, then normalises and rounds.
// ============================================================================
module vpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vpd_pkg::item_t in_item,
	input  logic [31:0]    scale,
	output logic           valid,
	input  logic           ready,
	output logic [31:0]    x_bits,
	output logic [31:0]    y_bits,
	output logic [31:0]    z_bits
);

	// Per component, stage 1: product and special-case result.
	typedef struct packed {
		logic        done;    // result already final
		logic [31:0] res;
		logic        sign;
		logic [40:0] prod;
		logic [7:0]  es;
	} mul_t;

	function automatic mul_t mul_stage(input vpd_pkg::comp_t c, input logic [31:0] s);
		mul_t  m;
		logic  ss;
		logic [7:0] es;
		logic [22:0] ms;
		logic [23:0] sig;
		ss  = s[31];
		es  = s[30:23];
		ms  = s[22:0];
		sig = (es != 8'd0) ? {1'b1, ms} : {1'b0, ms};
		m.sign = ss ^ c.neg;
		m.prod = 41'(sig) * 41'(c.word[16:0]);
		m.es   = (es == 8'd0) ? 8'd1 : es;
		m.done = 1'b1;
		m.res  = 32'd0;
		if (c.pass) begin
			m.res = c.word;
		end else if (es == 8'hFF) begin
			if (ms != 23'd0)            m.res = s | 32'h0040_0000;
			else if (c.word == 32'd0)   m.res = vpd_pkg::DEFAULT_NAN;
			else                        m.res = {m.sign, 31'h7F80_0000};
		end else if (c.word == 32'd0) begin
			m.res = {ss, 31'd0};
		end else if (es == 8'd0 && ms == 23'd0) begin
			m.res = {m.sign, 31'd0};
		end else begin
			m.done = 1'b0;
		end
		return m;
	endfunction

	// Stage 2: value = prod * 2^(es-150), round to binary32.
	function automatic logic [31:0] pack_stage(input mul_t m);
		logic [5:0]  p;
		logic signed [10:0] e, shift, lo;
		logic [40:0] q, rem, half, mask;
		logic signed [10:0] expf;
		logic [31:0] bits;
		if (m.done) return m.res;
		p = 6'd0;
		for (int i = 0; i < 41; i++)
			if (m.prod[i]) p = 6'(i);
		e     = 11'($signed({3'd0, m.es})) - 11'sd150;
		shift = $signed({5'd0, p}) - 11'sd23;
		lo    = -11'sd149 - e;
		if (lo > shift) shift = lo;
		if (shift <= 0) begin
			q = m.prod << 6'(-shift);
		end else if (shift > 11'sd41) begin
			q = 41'd0;   // shifted entirely below half
		end else begin
			q    = m.prod >> 6'(shift);
			mask = (41'd1 << 6'(shift)) - 41'd1;
			rem  = m.prod & mask;
			half = 41'd1 << 6'(shift - 11'sd1);
			if (rem > half || (rem == half && q[0])) q = q + 41'd1;
		end
		expf = e + shift + 11'sd149;
		if (expf >= 11'sd255) return {m.sign, 31'h7F80_0000};
		bits = 32'({expf[7:0], 23'd0}) + q[31:0];
		if (bits >= 32'h7F80_0000) return {m.sign, 31'h7F80_0000};
		return {m.sign, bits[30:0]};
	endfunction

	mul_t        mx_s1, my_s1, mz_s1;
	logic        fo_s1, v_s1, v_s2;
	logic        adv1;

	assign in_ready = !v_s1 || adv1;
	assign adv1     = !v_s2 || ready;
	assign valid    = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv1)     v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mx_s1 <= mul_stage(in_item.x, scale);
			my_s1 <= mul_stage(in_item.y, scale);
			mz_s1 <= mul_stage(in_item.z, scale);
			fo_s1 <= in_item.force_one;
		end
		if (adv1 && v_s1) begin
			x_bits <= pack_stage(mx_s1);
			y_bits <= pack_stage(my_s1);
			z_bits <= fo_s1 ? vpd_pkg::ONE_BITS : pack_stage(mz_s1);
		end
	end

endmodule

// ===== tb/vertex_position_dequantizer_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// vertex_position_dequantizer_core_tb - self-checking bench for the dequantiser
// Drives positions under several format, element-count and scale settings,
// predicts each binary32 result bit for bit and checks the results in order.
// ============================================================================

// Holds the positions still due out of the block, in transfer order, and
// compares each result that arrives against the oldest of them.
class position_scoreboard;
	logic [95:0] due_q[$];
	int unsigned mismatches;

	function void note_position(logic [95:0] expected);
		due_q.push_back(expected);
	endfunction

	function void check_position(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [95:0] e;
		if (due_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h %h %h", x, y, z);
			return;
		end
		e = due_q.pop_front();
		if (e != {x, y, z}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %h %h %h, got %h %h %h",
					e[95:64], e[63:32], e[31:0], x, y, z);
		end
	endfunction
endclass

module vertex_position_dequantizer_core_tb;

	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] raw_x, raw_y, raw_z;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] x_bits, y_bits, z_bits;

	// The bench's own copy of the configuration registers.
	logic [2:0]  fmt_cfg;
	logic        three_cfg;
	logic [31:0] scale_cfg;

	position_scoreboard sb;
	int unsigned idle_cycles;
	bit          sink_hold;   // set while the receiver is asked to hold off
	int unsigned sink_wait;   // cycles the receiver still waits before the next result
	int unsigned sink_draw;

	vertex_position_dequantizer_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Rounds sign * mag * 2^e to binary32, nearest even, with gradual underflow.
	// The magnitude is nonzero and below 2^40.
	function automatic logic [31:0] round_to_single(logic sgn, logic [63:0] mag, int e);
		int msb, shift, lo;
		logic [63:0] q, rem, half, packed_bits;
		int biased;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (mag[i])
				msb = i;
		shift = msb - 23;
		lo = -149 - e;
		if (lo > shift)
			shift = lo;
		if (shift <= 0) begin
			q = mag << (-shift);
		end else begin
			q = mag >> shift;
			rem = mag & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			// Round half to even: the kept part is bumped on ties only when odd.
			if (rem > half || (rem == half && q[0]))
				q = q + 64'd1;
		end
		biased = e + shift + 149;
		if (biased >= 255)
			return {sgn, 31'h7F80_0000};
		packed_bits = (64'(biased) << 23) + q;
		if (packed_bits >= 64'h7F80_0000)
			return {sgn, 31'h7F80_0000};
		return {sgn, packed_bits[30:0]};
	endfunction

	// Scales the signed integer (neg, mag) by the configured binary32 scale.
	function automatic logic [31:0] scale_integer(logic neg, logic [31:0] mag);
		logic        s_sign, sgn;
		logic [7:0]  s_exp;
		logic [22:0] s_man;
		logic [63:0] sig;
		int e;
		s_sign = scale_cfg[31];
		s_exp = scale_cfg[30:23];
		s_man = scale_cfg[22:0];
		sgn = s_sign ^ neg;
		if (s_exp == 8'hFF) begin
			// A NaN scale comes back quietened; zero times infinity is the default NaN.
			if (s_man != 0)
				return scale_cfg | 32'h0040_0000;
			if (mag == 0)
				return vpd_pkg::DEFAULT_NAN;
			return {sgn, 31'h7F80_0000};
		end
		// An integer zero counts as +0, so the product takes the scale's sign.
		if (mag == 0)
			return {s_sign, 31'd0};
		if (s_exp == 0 && s_man == 0)
			return {sgn, 31'd0};
		if (s_exp != 0) begin
			sig = {40'd0, 1'b1, s_man};
			e = int'(s_exp) - 150;
		end else begin
			sig = {41'd0, s_man};
			e = -149;
		end
		return round_to_single(sgn, sig * 64'(mag), e);
	endfunction

	function automatic logic [31:0] dequantise(logic [31:0] raw);
		case (fmt_cfg)
			vpd_pkg::FMT_UBYTE: return scale_integer(1'b0, {24'd0, raw[7:0]});
			vpd_pkg::FMT_SBYTE: begin
				if (raw[7])
					return scale_integer(1'b1, 32'h100 - {24'd0, raw[7:0]});
				return scale_integer(1'b0, {24'd0, raw[7:0]});
			end
			vpd_pkg::FMT_UHALF: return scale_integer(1'b0, {16'd0, raw[15:0]});
			vpd_pkg::FMT_SHALF: begin
				if (raw[15])
					return scale_integer(1'b1, 32'h10000 - {16'd0, raw[15:0]});
				return scale_integer(1'b0, {16'd0, raw[15:0]});
			end
			// Float and the unused codes pass the word through untouched.
			default: return raw;
		endcase
	endfunction

	// Writes one register, then drops the write enable again before returning.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vpd_pkg::REG_FORMAT: fmt_cfg = value[2:0];
			vpd_pkg::REG_THREE:  three_cfg = value[0];
			default:             scale_cfg = value;
		endcase
		@(posedge clk);
	endtask

	// Offers one position after a random gap and returns once it is transferred.
	// Valid stays high between back-to-back positions.
	task automatic send_position(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		raw_z <= z;
		do @(posedge clk); while (!in_ready);
		sb.note_position({dequantise(x), dequantise(y),
			three_cfg ? dequantise(z) : vpd_pkg::ONE_BITS});
	endtask

	// Drops valid and waits until every expected result is out, plus the
	// block's latency, so that the registers can be rewritten safely.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Random words biased towards the interesting corners of each format.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return {24'($urandom), 8'h80};
			2: return $urandom | 32'h0000_8000;
			3: return $urandom | 32'h0000_00FF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] random_scale();
		case ($urandom_range(0, 9))
			0: return 32'h7F80_0000 | ($urandom & 32'h8000_0000);
			1: return 32'h7F80_0000 | ($urandom & 32'h807F_FFFF) | 32'h1;
			2: return $urandom & 32'h807F_FFFF;                  // subnormal or zero
			3: return {$urandom_range(0, 1) == 1, 8'd1, 23'($urandom)};
			4: return {$urandom_range(0, 1) == 1, 8'hF0 + 8'($urandom_range(0, 14)),
				23'($urandom)};
			5: return {$urandom_range(0, 1) == 1, 8'd100 + 8'($urandom_range(0, 10)),
				23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Receiver: after each result it waits a randomly drawn delay before the
	// next, and holds off entirely while asked to.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				sb.check_position(x_bits, y_bits, z_bits);
				sink_draw = $urandom_range(0, 4);
				sink_wait <= sink_draw;
				out_ready <= (sink_draw == 0) && !sink_hold;
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
				out_ready <= (sink_wait == 1) && !sink_hold;
			end else begin
				out_ready <= !sink_hold;
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("vertex_position_dequantizer_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] scales[6];
		int n;
		sb = new();
		idle_cycles = 0;
		sink_hold = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = vpd_pkg::REG_FORMAT;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_x = '0;
		raw_y = '0;
		raw_z = '0;
		fmt_cfg = vpd_pkg::FMT_UBYTE;
		three_cfg = 1'b1;
		scale_cfg = vpd_pkg::ONE_BITS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, then each format with extremes of the fields.
		send_position(32'h0, 32'hFF, 32'hFFFF_FF80);
		for (int f = 0; f < 8; f++) begin
			drain();
			write_reg(vpd_pkg::REG_FORMAT, 32'(f));
			send_position(32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0080);
			send_position(32'h0, 32'h7F7F_7FFF, 32'hFF80_0001);
		end
		// Two elements: z forced to 1.0 whatever raw_z holds.
		drain();
		write_reg(vpd_pkg::REG_FORMAT, 32'(vpd_pkg::FMT_SHALF));
		write_reg(vpd_pkg::REG_THREE, 32'h0);
		send_position(32'h8000, 32'h7FFF, 32'hDEAD_BEEF);
		// Special scales: NaN, an infinity with zero input, negative zero, overflow, underflow.
		scales = '{32'h7F80_0001, 32'hFF80_0000, 32'h8000_0000, 32'h7F7F_FFFF,
			32'h0000_0001, 32'h8080_0000};
		for (int i = 0; i < 6; i++) begin
			drain();
			write_reg(vpd_pkg::REG_SCALE, scales[i]);
			write_reg(vpd_pkg::REG_THREE, 32'(i % 2));
			send_position(32'h0, 32'hFFFF_8000, 32'h0000_7FFF);
		end

		// Random phases with new settings between them, extremes included.
		for (int phase = 0; phase < 12; phase++) begin
			drain();
			write_reg(vpd_pkg::REG_FORMAT,
				32'($urandom_range(0, 7)) | ($urandom & 32'hFFFF_FFF8));
			write_reg(vpd_pkg::REG_THREE, $urandom);
			write_reg(vpd_pkg::REG_SCALE, random_scale());
			n = 50;
			if (phase == 3) begin
				// Long hold-off on the receiver while the sender keeps offering.
				fork
					begin
						sink_hold = 1'b1;
						repeat (60) @(posedge clk);
						sink_hold = 1'b0;
					end
				join_none
			end
			for (int i = 0; i < n; i++)
				send_position(random_word(), random_word(), random_word());
			if (phase == 6) begin
				// The sender pauses until everything in flight has come out.
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.due_q.size() != 0)
					@(posedge clk);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_q.size() == 0)
			$display("vertex_position_dequantizer_core_tb: PASS");
		else
			$display("vertex_position_dequantizer_core_tb: FAIL");
		$finish;
	end

endmodule
